FILE: design/sdse_pkg.sv
// constants and types shared by the smtp data stream encoder
// no dependencies
package sdse_pkg;

	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;

	localparam logic ACT_DATA = 1'b0;
	localparam logic ACT_EOM  = 1'b1;

	localparam int MAX_RES = 5;
	localparam int CNT_W   = $clog2(MAX_RES + 1);

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [MAX_RES-1:0][7:0] seq_t;

endpackage

FILE: design/sdse_msg_if.sv
// request channel carrying message bytes and end-of-message marks
// no dependencies
interface sdse_msg_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] data_byte;

	modport source (output valid, action, data_byte, input ready);
	modport sink   (input valid, action, data_byte, output ready);
endinterface

FILE: design/sdse_smtp_if.sv
// request channel carrying bytes of the escaped smtp data stream
// no dependencies
interface sdse_smtp_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;

	modport source (output valid, out_byte, last_of_run, input ready);
	modport sink   (input valid, out_byte, last_of_run, output ready);
endinterface

FILE: design/smtp_dot_stuff_crlf_encoder.sv
// smtp data stream encoder: dot stuffing, bare lf repair, message terminator
// depends on sdse_pkg, sdse_msg_if, sdse_smtp_if
//
// usage:
//   msg  : valid/ready channel of input requests; action 0 carries a message
//          byte in data_byte, action 1 closes the message
//   smtp : valid/ready channel of escaped output bytes; last_of_run marks the
//          final byte produced by one input request
// each accepted request is expanded combinationally into a short byte sequence
// (1 or 2 bytes for data, 3 or 5 for end of message) held in a sequence
// register, which feeds the output register one byte per cycle unless stalled.
// a request's bytes reach smtp through the sequence, then the output register.
// throughput: one output byte per cycle unless stalled; a request is taken
// in the cycle its predecessor's last byte moves to the output register, so
// single-byte requests flow at one per cycle, longer ones hold msg until done.
// a stalled smtp receiver holds the output register and, once the sequence
// register cannot drain, msg.ready drops.
// reset: line state returns to start of line, no bytes pending, no output.
module smtp_dot_stuff_crlf_encoder (
	input logic clk,
	input logic arst_n,
	sdse_msg_if.sink    msg,
	sdse_smtp_if.source smtp
);
	import sdse_pkg::*;

	logic at_line_start_q;
	logic prev_was_cr_q;
	logic last_was_lf_q;

	seq_t seq_s1;
	cnt_t cnt_s1;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	seq_t nseq;
	cnt_t ncnt;
	logic acc;
	logic adv;

	assign adv = (cnt_s1 != '0) && (!out_valid_q || smtp.ready);
	assign msg.ready = (cnt_s1 == '0) || ((cnt_s1 == cnt_t'(1)) && adv);
	assign acc = msg.valid && msg.ready;

	// expansion of one request
	always_comb begin
		nseq = '0;
		ncnt = '0;
		unique case (msg.action)
			ACT_EOM: begin
				if (last_was_lf_q) begin
					nseq[0] = CH_DOT;
					nseq[1] = CH_CR;
					nseq[2] = CH_LF;
					ncnt = cnt_t'(3);
				end else begin
					nseq[0] = CH_CR;
					nseq[1] = CH_LF;
					nseq[2] = CH_DOT;
					nseq[3] = CH_CR;
					nseq[4] = CH_LF;
					ncnt = cnt_t'(5);
				end
			end
			ACT_DATA: begin
				if (msg.data_byte == CH_LF && !prev_was_cr_q) begin
					nseq[0] = CH_CR;
					nseq[1] = CH_LF;
					ncnt = cnt_t'(2);
				end else if (msg.data_byte == CH_DOT && at_line_start_q) begin
					nseq[0] = CH_DOT;
					nseq[1] = CH_DOT;
					ncnt = cnt_t'(2);
				end else begin
					nseq[0] = msg.data_byte;
					ncnt = cnt_t'(1);
				end
			end
			default: begin
				nseq = '0;
				ncnt = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_line_start_q <= 1'b1;
			prev_was_cr_q   <= 1'b0;
			last_was_lf_q   <= 1'b0;
		end else if (acc) begin
			if (msg.action == ACT_EOM) begin
				at_line_start_q <= 1'b1;
				prev_was_cr_q   <= 1'b0;
				last_was_lf_q   <= 1'b0;
			end else begin
				at_line_start_q <= (msg.data_byte == CH_LF);
				prev_was_cr_q   <= (msg.data_byte == CH_CR);
				last_was_lf_q   <= (msg.data_byte == CH_LF);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s1 <= '0;
		end else if (acc) begin
			cnt_s1 <= ncnt;
		end else if (adv) begin
			cnt_s1 <= cnt_s1 - cnt_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			seq_s1 <= nseq;
		end else if (adv) begin
			seq_s1 <= seq_s1 >> 8;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (smtp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q <= seq_s1[0];
			out_last_q <= (cnt_s1 == cnt_t'(1));
		end
	end

	assign smtp.valid       = out_valid_q;
	assign smtp.out_byte    = out_byte_q;
	assign smtp.last_of_run = out_last_q;

`ifndef ASSERT_OFF
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_s1 <= cnt_t'(MAX_RES))
		else $error("pending byte count out of range");

	a_eom_len: assert property (@(posedge clk) disable iff (!arst_n)
		acc && msg.action == ACT_EOM |=> cnt_s1 == cnt_t'(3) || cnt_s1 == cnt_t'(5))
		else $error("end of message expansion has wrong length");

	a_eom_state: assert property (@(posedge clk) disable iff (!arst_n)
		acc && msg.action == ACT_EOM |=> at_line_start_q && !prev_was_cr_q && !last_was_lf_q)
		else $error("line state not cleared after end of message");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> cnt_s1 == '0 || (cnt_s1 == cnt_t'(1) && adv))
		else $error("request taken while bytes still pending");
`endif

endmodule
